/* rtl/core/assert_macros.svh */
// Assertion macros used by the scheduler core (pts_core).
// Each macro expands to a concurrent assertion, or to nothing in synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPL(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
`define ASSERT_NEXT(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPL(lbl, clk, rst_n, a, c)
`define ASSERT_NEXT(lbl, clk, rst_n, a, c)
`endif
`endif

/* rtl/core/pts_pkg.sv */
// Package for the priority thread scheduler.
// Holds sizes, command codes, states, payload and table entry types and helpers; no dependencies.
package pts_pkg;
    localparam int NUM_THREADS    = 8;
    localparam int NUM_SEMAPHORES = 8;
    localparam int PRIORITY_BITS  = 8;
    localparam int TW     = $clog2(NUM_THREADS);
    localparam int CW     = TW + 1;
    localparam int SEM_AW = (NUM_SEMAPHORES > 1) ? $clog2(NUM_SEMAPHORES) : 1;
    localparam logic [7:0] NEVER_PRIORITY = 8'd255;
    localparam logic signed [15:0] SEMA_MAX = 16'sh7FFF;
    localparam logic signed [15:0] SEMA_MIN = 16'sh8000;
    localparam logic [2:0] REG_PRIO_ADDR = 3'd0;

    typedef enum logic [2:0] {
        CMD_TICK   = 3'd0,
        CMD_SCHED  = 3'd1,
        CMD_SLEEP  = 3'd2,
        CMD_WAIT   = 3'd3,
        CMD_SIGNAL = 3'd4,
        CMD_INIT   = 3'd5
    } t_cmd;

    typedef enum logic [3:0] {
        S_IDLE,
        S_TICK,
        S_SLP_WR,
        S_SEM_WR,
        S_BLK_WR,
        S_SCAN,
        S_WSCAN,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [2:0]         cmd;
        logic [31:0]        sleep_time;
        logic [2:0]         sema_id;
        logic signed [15:0] init_value;
    } t_in;

    typedef struct packed {
        logic [2:0]         running_thread;
        logic               none_ready;
        logic signed [15:0] sema_count;
        logic               woke_valid;
        logic [2:0]         woke_thread;
        logic               caller_blocked;
    } t_out;

    typedef struct packed {
        logic [31:0]       sleep;
        logic              blk;
        logic [SEM_AW-1:0] on;
    } t_thr;

    localparam int THR_W = $bits(t_thr);

    function automatic logic [7:0] prio_of(input logic [63:0] pri, input logic [TW-1:0] t);
        int sh;
        sh = 8 * int'(t);
        if (sh >= 64) begin
            return 8'd0;
        end
        return 8'(PRIORITY_BITS'(pri >> sh));
    endfunction

    function automatic logic [TW-1:0] next_t(input logic [TW-1:0] t);
        if (t == TW'(NUM_THREADS - 1)) begin
            return '0;
        end
        return t + TW'(1);
    endfunction
endpackage

/* rtl/core/pts_ram.sv */
// Generic single-write, single-read RAM with a registered read.
// No package dependencies.
module pts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

/* rtl/core/pts_core.sv */
// Command sequencer of the scheduler: reads, modifies and writes the thread
// and semaphore tables. Depends on pts_pkg, pts_ram and assert_macros.svh.
`include "assert_macros.svh"
module pts_core import pts_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [63:0] i_prio,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in         i_in_data,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out        o_out_data
);
    t_state r_state, n_state;
    t_cmd   r_cmd, n_cmd;
    logic [31:0] r_stime, n_stime;
    logic [SEM_AW-1:0] r_sid, n_sid;
    logic [TW-1:0] r_run, n_run, r_addr, n_addr, r_rda, n_rda, r_pick, n_pick, r_wt, n_wt;
    logic [CW-1:0] r_cnt, n_cnt;
    logic r_rdv, n_rdv, r_found, n_found, r_none, n_none, r_woke, n_woke, r_blk, n_blk;
    logic [7:0] r_best, n_best;
    logic signed [15:0] r_scnt, n_scnt;
    logic [NUM_THREADS-1:0] r_tval, n_tval;
    logic [NUM_SEMAPHORES-1:0] r_sval, n_sval;
    logic r_trv, r_srv;
    t_out r_out, n_out;
    logic r_ovld, n_ovld;

    logic t_we, s_we;
    logic [TW-1:0] t_waddr, t_raddr;
    t_thr t_wdata, t_q, t_rd;
    logic [SEM_AW-1:0] s_waddr, s_raddr;
    logic signed [15:0] s_wdata, s_q, s_rd;
    logic accept, sid_ok, issue, out_load;
    logic signed [15:0] nc;
    logic [7:0] p;

    assign accept = i_in_valid && o_in_ready;
    assign o_in_ready = (r_state == S_IDLE);
    assign o_out_valid = r_ovld;
    assign o_out_data = r_out;
    assign sid_ok = ({29'd0, i_in_data.sema_id} < 32'(NUM_SEMAPHORES));
    assign t_rd = r_trv ? t_q : '0;
    assign s_rd = r_srv ? s_q : '0;
    assign issue = (r_state == S_TICK || r_state == S_SCAN || r_state == S_WSCAN)
                   && (r_cnt < CW'(NUM_THREADS));
    assign out_load = (r_state == S_DONE) && (!r_ovld || i_out_ready);

    pts_ram #(.WIDTH(THR_W), .DEPTH(NUM_THREADS)) u_thr (
        .i_clk(i_clk), .i_we(t_we), .i_waddr(t_waddr), .i_wdata(t_wdata),
        .i_raddr(t_raddr), .o_rdata(t_q)
    );

    pts_ram #(.WIDTH(16), .DEPTH(NUM_SEMAPHORES)) u_sem (
        .i_clk(i_clk), .i_we(s_we), .i_waddr(s_waddr), .i_wdata(s_wdata),
        .i_raddr(s_raddr), .o_rdata(s_q)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (t_cmd'(i_in_data.cmd))
                        CMD_TICK:   n_state = S_TICK;
                        CMD_SCHED:  n_state = S_SCAN;
                        CMD_SLEEP:  n_state = S_SLP_WR;
                        CMD_WAIT,
                        CMD_SIGNAL: n_state = sid_ok ? S_SEM_WR : S_DONE;
                        default:    n_state = S_DONE;
                    endcase
                end
            end
            S_TICK:   n_state = (r_cnt == CW'(NUM_THREADS)) ? S_DONE : S_TICK;
            S_SLP_WR: n_state = S_SCAN;
            S_BLK_WR: n_state = S_SCAN;
            S_SEM_WR: begin
                if (r_cmd == CMD_WAIT) begin
                    n_state = (nc < 0) ? S_BLK_WR : S_DONE;
                end else begin
                    n_state = (nc <= 0) ? S_WSCAN : S_DONE;
                end
            end
            S_SCAN:   n_state = (r_cnt == CW'(NUM_THREADS)) ? S_DONE : S_SCAN;
            S_WSCAN: begin
                if ((r_rdv && t_rd.blk && t_rd.on == r_sid) || r_cnt == CW'(NUM_THREADS)) begin
                    n_state = S_DONE;
                end
            end
            S_DONE:   n_state = out_load ? S_IDLE : S_DONE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_cmd = r_cmd; n_stime = r_stime; n_sid = r_sid; n_run = r_run;
        n_addr = r_addr; n_cnt = r_cnt; n_rda = r_addr; n_rdv = issue;
        n_best = r_best; n_pick = r_pick; n_found = r_found;
        n_none = r_none; n_scnt = r_scnt; n_woke = r_woke; n_wt = r_wt; n_blk = r_blk;
        n_tval = r_tval; n_sval = r_sval;
        n_out = r_out;
        n_ovld = r_ovld && !i_out_ready;
        t_we = 1'b0; t_waddr = r_rda; t_wdata = t_rd; t_raddr = r_addr;
        s_we = 1'b0; s_waddr = r_sid; s_wdata = '0; s_raddr = SEM_AW'(i_in_data.sema_id);
        nc = s_rd;
        p = prio_of(i_prio, r_rda);
        if (issue) begin
            n_addr = next_t(r_addr);
            n_cnt = r_cnt + CW'(1);
        end
        case (r_state)
            S_IDLE: begin
                t_raddr = r_run;
                if (accept) begin
                    n_cmd = t_cmd'(i_in_data.cmd);
                    n_stime = i_in_data.sleep_time;
                    n_sid = SEM_AW'(i_in_data.sema_id);
                    n_cnt = '0;
                    n_addr = (t_cmd'(i_in_data.cmd) == CMD_TICK) ? '0 : next_t(r_run);
                    n_best = NEVER_PRIORITY; n_pick = r_run; n_found = 1'b0;
                    n_none = 1'b0; n_scnt = '0; n_woke = 1'b0; n_wt = '0; n_blk = 1'b0;
                    if (t_cmd'(i_in_data.cmd) == CMD_INIT && sid_ok) begin
                        s_we = 1'b1;
                        s_waddr = SEM_AW'(i_in_data.sema_id);
                        s_wdata = i_in_data.init_value;
                        n_sval[SEM_AW'(i_in_data.sema_id)] = 1'b1;
                        n_scnt = i_in_data.init_value;
                    end
                end
            end
            S_TICK: begin
                if (r_rdv) begin
                    t_we = 1'b1;
                    if (t_rd.sleep != 32'd0) begin
                        t_wdata.sleep = t_rd.sleep - 32'd1;
                    end
                    n_tval[r_rda] = 1'b1;
                end
            end
            S_SLP_WR: begin
                t_we = 1'b1; t_waddr = r_run;
                t_wdata.sleep = r_stime;
                n_tval[r_run] = 1'b1;
            end
            S_SEM_WR: begin
                t_raddr = r_run;
                if (r_cmd == CMD_WAIT) begin
                    nc = (s_rd == SEMA_MIN) ? s_rd : s_rd - 16'sd1;
                    n_blk = (nc < 0);
                end else begin
                    nc = (s_rd == SEMA_MAX) ? s_rd : s_rd + 16'sd1;
                end
                s_we = 1'b1; s_wdata = nc;
                n_sval[r_sid] = 1'b1;
                n_scnt = nc;
            end
            S_BLK_WR: begin
                t_we = 1'b1; t_waddr = r_run;
                t_wdata.blk = 1'b1; t_wdata.on = r_sid;
                n_tval[r_run] = 1'b1;
            end
            S_SCAN: begin
                if (r_rdv && p < n_best && !t_rd.blk && t_rd.sleep == 32'd0) begin
                    n_best = p; n_pick = r_rda; n_found = 1'b1;
                end
                if (r_cnt == CW'(NUM_THREADS)) begin
                    n_run = n_found ? n_pick : r_run;
                    n_none = !n_found;
                end
            end
            S_WSCAN: begin
                if (r_rdv && t_rd.blk && t_rd.on == r_sid) begin
                    t_we = 1'b1; t_wdata.blk = 1'b0;
                    n_woke = 1'b1; n_wt = r_rda;
                end
            end
            S_DONE: begin
                if (out_load) begin
                    n_ovld = 1'b1;
                    n_out.running_thread = 3'(r_run);
                    n_out.none_ready = r_none;
                    n_out.sema_count = r_scnt;
                    n_out.woke_valid = r_woke;
                    n_out.woke_thread = 3'(r_wt);
                    n_out.caller_blocked = r_blk;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_run <= '0;
            r_tval <= '0;
            r_sval <= '0;
            r_ovld <= 1'b0;
            r_rdv <= 1'b0;
        end else begin
            r_state <= n_state;
            r_run <= n_run;
            r_tval <= n_tval;
            r_sval <= n_sval;
            r_ovld <= n_ovld;
            r_rdv <= n_rdv;
        end
        r_cmd <= n_cmd; r_stime <= n_stime; r_sid <= n_sid;
        r_addr <= n_addr; r_cnt <= n_cnt; r_rda <= n_rda;
        r_best <= n_best; r_pick <= n_pick; r_found <= n_found;
        r_none <= n_none; r_scnt <= n_scnt; r_woke <= n_woke; r_wt <= n_wt; r_blk <= n_blk;
        r_out <= n_out;
        r_trv <= r_tval[t_raddr];
        r_srv <= r_sval[s_raddr];
    end

    `ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, accept, r_state != S_IDLE)
    `ASSERT_IMPL(a_woke_sig, i_clk, i_rst_n, r_state == S_DONE && r_woke, r_cmd == CMD_SIGNAL)
    `ASSERT_IMPL(a_blk_wait, i_clk, i_rst_n, r_state == S_DONE && r_blk, r_cmd == CMD_WAIT)
endmodule

/* rtl/core/priority_thread_scheduler.sv */
// Top level of the priority thread scheduler: priority register port and core.
// Depends on pts_pkg and pts_core.
//
// Channel   Direction  Handshake                    Payload
// input     in         i_in_valid / o_in_ready      i_in_data (t_in)
// output    out        o_out_valid / i_out_ready    o_out_data (t_out)
// config    in         psel, penable, pwrite        paddr, pwdata, prdata
//
// A tick or schedule reads the thread table once per thread, one read per cycle. Sleep
// writes the sleep time, a blocking wait the semaphore and block flag, then both scan;
// other waits and signals write the semaphore, and a signal with a count not above zero
// scans for a waiter. Reset is synchronous and clears the tables through valid bits.
// A finished transaction waits in the output register while the next one is taken in.
module priority_thread_scheduler import pts_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in         i_in_data,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out        o_out_data,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);
    logic [63:0] r_prio, n_prio;

    assign pready = 1'b1;
    assign prdata = (paddr == REG_PRIO_ADDR) ? r_prio : 64'd0;

    always_comb begin
        n_prio = r_prio;
        if (psel && penable && pwrite && paddr == REG_PRIO_ADDR) begin
            n_prio = pwdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prio <= 64'd0;
        end else begin
            r_prio <= n_prio;
        end
    end

    pts_core u_core (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_prio(r_prio),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready), .i_in_data(i_in_data),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready), .o_out_data(o_out_data)
    );
endmodule

/* sim/testbench.sv */
// Self-checking testbench for priority_thread_scheduler.
// Drives commands and the priority register, predicts each result in a local
// model of the thread and semaphore tables, and compares; depends on pts_pkg.
module testbench;
    import pts_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int RANDOM_ITEMS = 1900;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    t_in         i_in_data = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    t_out        o_out_data;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [63:0] pwdata = '0;
    logic [63:0] prdata;
    logic        pready;

    priority_thread_scheduler i_dut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Scheduler state as predicted.
    logic [63:0]        pri_reg;
    logic [2:0]         cur_thread;
    logic [31:0]        naps [NUM_THREADS];
    logic               held [NUM_THREADS];
    logic [2:0]         held_on [NUM_THREADS];
    logic signed [15:0] counts [NUM_SEMAPHORES];

    t_out pending_results[$];
    int   errors = 0;
    int   cycles = 0;
    bit   stall_long = 1'b0;
    bit   feeding_done = 1'b0;

    function automatic logic pick_next();
        logic [7:0] best;
        logic [2:0] choice;
        logic       found;
        logic [2:0] t;
        logic [7:0] p;
        best = NEVER_PRIORITY;
        choice = cur_thread;
        found = 1'b0;
        for (int k = 1; k <= NUM_THREADS; k++) begin
            t = 3'((int'(cur_thread) + k) % NUM_THREADS);
            p = 8'(pri_reg >> (8 * int'(t)));
            if (p < best && !held[t] && naps[t] == 0) begin
                best = p;
                choice = t;
                found = 1'b1;
            end
        end
        cur_thread = choice;
        return !found;
    endfunction

    function automatic t_out predict_command(t_in item);
        t_out r;
        logic [2:0] t;
        r = '0;
        case (item.cmd)
            CMD_TICK: begin
                for (int i = 0; i < NUM_THREADS; i++) begin
                    if (naps[i] != 0) naps[i] = naps[i] - 1;
                end
            end
            CMD_SCHED: r.none_ready = pick_next();
            CMD_SLEEP: begin
                naps[cur_thread] = item.sleep_time;
                r.none_ready = pick_next();
            end
            CMD_WAIT: begin
                if (counts[item.sema_id] != SEMA_MIN) counts[item.sema_id]--;
                r.sema_count = counts[item.sema_id];
                if (r.sema_count < 0) begin
                    held[cur_thread] = 1'b1;
                    held_on[cur_thread] = item.sema_id;
                    r.caller_blocked = 1'b1;
                    r.none_ready = pick_next();
                end
            end
            CMD_SIGNAL: begin
                if (counts[item.sema_id] != SEMA_MAX) counts[item.sema_id]++;
                r.sema_count = counts[item.sema_id];
                if (r.sema_count <= 0) begin
                    for (int k = 1; k <= NUM_THREADS; k++) begin
                        t = 3'((int'(cur_thread) + k) % NUM_THREADS);
                        if (!r.woke_valid && held[t] && held_on[t] == item.sema_id) begin
                            held[t] = 1'b0;
                            r.woke_valid = 1'b1;
                            r.woke_thread = t;
                        end
                    end
                end
            end
            CMD_INIT: begin
                counts[item.sema_id] = item.init_value;
                r.sema_count = item.init_value;
            end
            default: ;
        endcase
        r.running_thread = cur_thread;
        return r;
    endfunction

    task automatic write_priorities(logic [63:0] value);
        @(posedge i_clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= REG_PRIO_ADDR;
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        pri_reg = value;
    endtask

    // Sends one transaction; a directed expectation overrides the prediction.
    task automatic send_command(t_in item, bit typed, t_out typed_result);
        t_out r;
        r = predict_command(item);
        if (typed) r = typed_result;
        pending_results.push_back(r);
        @(posedge i_clk);
        i_in_valid <= 1'b1;
        i_in_data <= item;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        i_in_valid <= 1'b0;
    endtask

    task automatic random_gap();
        int g;
        g = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
        if ($urandom_range(0, 3) == 0) g = 0;
        repeat (g) @(posedge i_clk);
    endtask

    task automatic drain();
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    function automatic t_in make_item(t_cmd c, logic [31:0] st, logic [2:0] s,
                                      logic [15:0] v);
        t_in x;
        x.cmd = c;
        x.sleep_time = st;
        x.sema_id = s;
        x.init_value = v;
        return x;
    endfunction

    function automatic t_in random_item();
        t_in x;
        x.sleep_time = ($urandom_range(0, 30) == 0) ? $urandom() : $urandom_range(0, 6);
        x.sema_id = 3'($urandom_range(0, 3) == 0 ? $urandom_range(0, 7) : $urandom_range(0, 1));
        x.init_value = ($urandom_range(0, 9) == 0) ? 16'($urandom()) :
                       16'($urandom_range(0, 4) - 2);
        case ($urandom_range(0, 19))
            0, 1, 2, 3, 4:  x.cmd = CMD_TICK;
            5, 6, 7:        x.cmd = CMD_SCHED;
            8, 9:           x.cmd = CMD_SLEEP;
            10, 11, 12:     x.cmd = CMD_WAIT;
            13, 14, 15, 16: x.cmd = CMD_SIGNAL;
            17:             x.cmd = CMD_INIT;
            default:        x.cmd = t_cmd'(3'($urandom_range(0, 7)));
        endcase
        return x;
    endfunction

    typedef struct {
        t_in  item;
        bit   typed;
        t_out result;
    } t_row;

    t_row directed [$];

    function automatic t_out res(logic [2:0] rt, logic nr, logic [15:0] sc, logic wv,
                                 logic [2:0] wt, logic cb);
        t_out r;
        r.running_thread = rt;
        r.none_ready = nr;
        r.sema_count = sc;
        r.woke_valid = wv;
        r.woke_thread = wt;
        r.caller_blocked = cb;
        return r;
    endfunction

    initial begin
        logic [63:0] settings [4];
        pri_reg = '0;
        cur_thread = '0;
        for (int i = 0; i < NUM_THREADS; i++) begin
            naps[i] = '0;
            held[i] = 1'b0;
            held_on[i] = '0;
        end
        for (int i = 0; i < NUM_SEMAPHORES; i++) counts[i] = '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // All priorities zero after reset: the scan wraps to the next thread.
        directed.push_back('{make_item(CMD_SCHED, 0, 0, 0), 1, res(1, 0, 0, 0, 0, 0)});
        directed.push_back('{make_item(CMD_INIT, 0, 7, 16'h7FFF), 1,
                             res(1, 0, 16'h7FFF, 0, 0, 0)});
        directed.push_back('{make_item(CMD_SIGNAL, 0, 7, 0), 1,
                             res(1, 0, 16'h7FFF, 0, 0, 0)});
        directed.push_back('{make_item(CMD_INIT, 0, 6, 16'h8000), 1,
                             res(1, 0, 16'h8000, 0, 0, 0)});
        directed.push_back('{make_item(CMD_WAIT, 0, 6, 0), 0, '0});
        directed.push_back('{make_item(CMD_SIGNAL, 0, 6, 0), 0, '0});
        directed.push_back('{make_item(CMD_SIGNAL, 0, 5, 0), 0, '0});
        directed.push_back('{make_item(CMD_SLEEP, 32'hFFFF_FFFF, 0, 0), 0, '0});
        directed.push_back('{make_item(CMD_TICK, 0, 0, 0), 0, '0});
        directed.push_back('{make_item(t_cmd'(3'd6), 32'hFFFF_FFFF, 7, 16'hFFFF), 0, '0});
        directed.push_back('{make_item(t_cmd'(3'd7), 0, 0, 0), 0, '0});
        for (int i = 0; i < 8; i++) begin
            directed.push_back('{make_item(CMD_WAIT, 32'h5555_5555, 0, 16'hAAAA), 0, '0});
        end
        directed.push_back('{make_item(CMD_SCHED, 0, 0, 0), 0, '0});
        directed.push_back('{make_item(CMD_SIGNAL, 32'hAAAA_AAAA, 0, 16'h5555), 0, '0});
        directed.push_back('{make_item(CMD_SCHED, 0, 0, 0), 0, '0});
        foreach (directed[i]) begin
            send_command(directed[i].item, directed[i].typed, directed[i].result);
        end
        drain();

        settings[0] = 64'hFFFF_FFFF_FFFF_FFFF;
        settings[1] = 64'h0706_0504_0302_0100;
        settings[2] = 64'hFF00_FF01_0203_FF80;
        settings[3] = 64'h0;
        for (int phase = 0; phase < 6; phase++) begin
            write_priorities(phase < 4 ? settings[phase] : {$urandom(), $urandom()});
            for (int i = 0; i < NUM_SEMAPHORES; i++) begin
                send_command(make_item(CMD_INIT, 0, 3'(i), 16'($urandom_range(0, 2))),
                             0, '0);
            end
            for (int n = 0; n < RANDOM_ITEMS / 6; n++) begin
                if (phase == 2 && n == 40) stall_long = 1'b1;
                if (phase == 3 && n == 100) drain();
                send_command(random_item(), 0, '0);
                random_gap();
            end
            drain();
        end
        feeding_done = 1'b1;
    end

    // Result side: random back-pressure, one long hold-off on request.
    initial begin
        forever begin
            @(posedge i_clk);
            if (stall_long) begin
                i_out_ready <= 1'b0;
                repeat (200) @(posedge i_clk);
                stall_long = 1'b0;
            end else if ($urandom_range(0, 40) == 0) begin
                i_out_ready <= 1'b0;
                repeat ($urandom_range(5, 25)) @(posedge i_clk);
            end else begin
                i_out_ready <= ($urandom_range(0, 9) == 0) ? 1'b0 : 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result %p", $time, o_out_data);
                errors++;
            end else begin
                want = pending_results.pop_front();
                if (o_out_data !== want) begin
                    $display("%0t: mismatch expected %p actual %p", $time, want, o_out_data);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (feeding_done) begin
            if (pending_results.size() != 0 || errors < 0) begin
                $display("FAIL priority_thread_scheduler");
            end else if (errors == 0) begin
                $display("PASS priority_thread_scheduler");
            end else begin
                $display("FAIL priority_thread_scheduler");
            end
            $finish;
        end else if (cycles > CYCLE_LIMIT) begin
            $display("%0t: timeout", $time);
            $display("FAIL priority_thread_scheduler");
            $finish;
        end
    end
endmodule

/* sim.f */
+incdir+rtl/core
rtl/core/pts_pkg.sv
rtl/core/pts_ram.sv
rtl/core/pts_core.sv
rtl/core/priority_thread_scheduler.sv
sim/testbench.sv
